FILE: hdl/crrm_pkg.sv
// types, event codes and counter slots for the call record return matcher
// no dependencies
package crrm_pkg;

    typedef enum logic [1:0] {
        KIND_RET   = 2'd0,
        KIND_DCALL = 2'd1,
        KIND_ICALL = 2'd2,
        KIND_BLOCK = 2'd3
    } t_kind;

    localparam int CNT_NUM = 7;
    localparam logic [2:0] CNT_INSTR   = 3'd0;
    localparam logic [2:0] CNT_RET     = 3'd1;
    localparam logic [2:0] CNT_DCALL   = 3'd2;
    localparam logic [2:0] CNT_ICALL   = 3'd3;
    localparam logic [2:0] CNT_DMATCH  = 3'd4;
    localparam logic [2:0] CNT_IMATCH  = 3'd5;
    localparam logic [2:0] CNT_IRMATCH = 3'd6;

    localparam int NEAR_LO = 2;
    localparam int NEAR_HI = 7;

    typedef struct packed {
        logic irec_match;
        logic icall_match;
        logic dcall_match;
    } t_match;

    function automatic logic near_return(input logic [63:0] ret_addr,
                                         input logic [63:0] entry);
        logic hit;
        hit = 1'b0;
        for (int d = NEAR_LO; d <= NEAR_HI; d++) begin
            if (ret_addr - 64'(d) == entry) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

FILE: hdl/call_record_return_matcher_top.sv
// call record return matcher: two call rings in synchronous memories and
// seven running event counters; depends on crrm_pkg
//
// Each input item is one retired-instruction event: a return, a direct call,
// an indirect call or a basic-block instruction count, and each gives one
// result item with three match flags and the seven running totals. Calls and
// block counts load the result register directly; a return first passes
// through the read state, since the newest entry of each ring is read from a
// synchronous memory before the compares. The next item is accepted while a
// finished result waits, as long as no return lookup runs and the result
// register is free or being taken in that cycle. The ring memories have no
// reset and need no clearing pass; only values from written slots are used.
module call_record_return_matcher_top #(
    parameter int DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [63:0] address, [95:64] block_instructions
    input  logic [95:0]  i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [0] direct_call_match, [1] indirect_call_match, [2] indirect_record_match,
    // [66:3] instruction_total, [130:67] return_total, [194:131] direct_call_total,
    // [258:195] indirect_call_total, [322:259] direct_match_total,
    // [386:323] indirect_match_total, [450:387] indirect_record_match_total,
    // [455:451] zero
    output logic [455:0] o_m_axis_tdata
);
    import crrm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_call_head, n_call_head;
    logic [AW-1:0] r_call_tail, n_call_tail;
    logic [AW-1:0] r_ind_head, n_ind_head;
    logic [AW-1:0] r_ind_tail, n_ind_tail;
    logic [63:0]   r_cnt [CNT_NUM];
    logic [63:0]   n_cnt [CNT_NUM];
    logic          r_out_valid, n_out_valid;
    t_match        r_match, n_match;
    logic [63:0]   r_ret_addr, n_ret_addr;

    logic [64:0]   r_call_mem [DEPTH];
    logic [63:0]   r_ind_mem [DEPTH];
    logic [64:0]   r_call_rd;
    logic [63:0]   r_ind_rd;

    logic          w_acc;
    logic          w_take;
    t_kind         w_kind;
    logic [63:0]   w_addr;
    logic [31:0]   w_nins;
    logic          w_call_we;
    logic          w_call_direct;
    logic          w_ind_we;
    logic [AW-1:0] w_call_prev;
    logic [AW-1:0] w_ind_prev;
    logic [AW-1:0] w_call_next;
    logic [AW-1:0] w_ind_next;
    logic [63:0]   w_top_addr;
    logic          w_top_direct;
    logic [63:0]   w_itop;
    logic          w_call_hit;
    logic          w_ind_hit;

    assign w_kind = t_kind'(i_s_axis_tuser);
    assign w_addr = i_s_axis_tdata[63:0];
    assign w_nins = i_s_axis_tdata[95:64];

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_take = r_out_valid && i_m_axis_tready;

    assign w_call_prev = (r_call_head == '0) ? LAST : r_call_head - 1'b1;
    assign w_ind_prev  = (r_ind_head == '0) ? LAST : r_ind_head - 1'b1;
    assign w_call_next = (r_call_head == LAST) ? '0 : r_call_head + 1'b1;
    assign w_ind_next  = (r_ind_head == LAST) ? '0 : r_ind_head + 1'b1;

    // empty record reads as address zero, flagged indirect
    assign w_top_addr   = (r_call_head != r_call_tail) ? r_call_rd[63:0] : 64'd0;
    assign w_top_direct = (r_call_head != r_call_tail) ? r_call_rd[64] : 1'b0;
    assign w_itop       = (r_ind_head != r_ind_tail) ? r_ind_rd : 64'd0;
    assign w_call_hit   = near_return(r_ret_addr, w_top_addr);
    assign w_ind_hit    = near_return(r_ret_addr, w_itop);

    always_comb begin
        n_state     = r_state;
        n_call_head = r_call_head;
        n_call_tail = r_call_tail;
        n_ind_head  = r_ind_head;
        n_ind_tail  = r_ind_tail;
        n_cnt       = r_cnt;
        n_match     = r_match;
        n_ret_addr  = r_ret_addr;
        n_out_valid = r_out_valid && !w_take;
        w_call_we     = 1'b0;
        w_call_direct = 1'b0;
        w_ind_we      = 1'b0;

        if (r_state == S_READ) begin
            n_cnt[CNT_RET] = r_cnt[CNT_RET] + 64'd1;
            n_match = '0;
            if (w_call_hit) begin
                if (w_top_direct) begin
                    n_match.dcall_match = 1'b1;
                    n_cnt[CNT_DMATCH] = r_cnt[CNT_DMATCH] + 64'd1;
                end else begin
                    n_match.icall_match = 1'b1;
                    n_cnt[CNT_IMATCH] = r_cnt[CNT_IMATCH] + 64'd1;
                end
            end
            if (w_ind_hit) begin
                n_match.irec_match = 1'b1;
                n_cnt[CNT_IRMATCH] = r_cnt[CNT_IRMATCH] + 64'd1;
            end
            if (r_call_head != r_call_tail) begin
                n_call_head = w_call_prev;
            end
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
        end else if (w_acc) begin
            case (w_kind)
                KIND_RET: begin
                    n_ret_addr = w_addr;
                    n_state    = S_READ;
                end
                KIND_DCALL: begin
                    w_call_we     = 1'b1;
                    w_call_direct = 1'b1;
                    n_call_head   = w_call_next;
                    if (w_call_next == r_call_tail) begin
                        n_call_tail = (r_call_tail == LAST) ? '0 : r_call_tail + 1'b1;
                    end
                    n_cnt[CNT_DCALL] = r_cnt[CNT_DCALL] + 64'd1;
                    n_match     = '0;
                    n_out_valid = 1'b1;
                end
                KIND_ICALL: begin
                    w_call_we   = 1'b1;
                    w_ind_we    = 1'b1;
                    n_call_head = w_call_next;
                    if (w_call_next == r_call_tail) begin
                        n_call_tail = (r_call_tail == LAST) ? '0 : r_call_tail + 1'b1;
                    end
                    n_ind_head = w_ind_next;
                    if (w_ind_next == r_ind_tail) begin
                        n_ind_tail = (r_ind_tail == LAST) ? '0 : r_ind_tail + 1'b1;
                    end
                    n_cnt[CNT_ICALL] = r_cnt[CNT_ICALL] + 64'd1;
                    n_match     = '0;
                    n_out_valid = 1'b1;
                end
                default: begin
                    n_cnt[CNT_INSTR] = r_cnt[CNT_INSTR] + {32'd0, w_nins};
                    n_match     = '0;
                    n_out_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_call_we) begin
            r_call_mem[r_call_head] <= {w_call_direct, w_addr};
        end
        r_call_rd <= r_call_mem[w_call_prev];
    end

    always_ff @(posedge i_clk) begin
        if (w_ind_we) begin
            r_ind_mem[r_ind_head] <= w_addr;
        end
        r_ind_rd <= r_ind_mem[w_ind_prev];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_call_head <= '0;
            r_call_tail <= '0;
            r_ind_head  <= '0;
            r_ind_tail  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CNT_NUM; i++) begin
                r_cnt[i] <= 64'd0;
            end
        end else begin
            r_state     <= n_state;
            r_call_head <= n_call_head;
            r_call_tail <= n_call_tail;
            r_ind_head  <= n_ind_head;
            r_ind_tail  <= n_ind_tail;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_match    <= n_match;
        r_ret_addr <= n_ret_addr;
    end

    // totals only change when a result is loaded, so they drive the port directly
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0,
                              r_cnt[CNT_IRMATCH], r_cnt[CNT_IMATCH], r_cnt[CNT_DMATCH],
                              r_cnt[CNT_ICALL], r_cnt[CNT_DCALL], r_cnt[CNT_RET],
                              r_cnt[CNT_INSTR],
                              r_match.irec_match, r_match.icall_match,
                              r_match.dcall_match};

    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (!o_s_axis_tready && !r_out_valid))
        else $error("input taken or result pending during return lookup");

    a_return_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_kind == KIND_RET) |=> (r_state == S_READ))
        else $error("return item did not start a lookup");

    a_one_call_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_match.dcall_match, r_match.icall_match}))
        else $error("both call record match flags set");

    a_call_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_kind != KIND_RET) |=> (r_out_valid && r_match == '0))
        else $error("non-return item gave no clean result");

endmodule
